FILE: rtl/cot_pkg.sv
package cot_pkg;

    localparam int COT_QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_PPM_SCALE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA            = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PPM_LIMIT        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TIMEOUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLISH_PERIOD   = 3'd5;

    localparam logic [33:0] RST_PPM_SCALE        = 34'd1175948265;
    localparam logic [16:0] RST_ALPHA            = 17'd19661;
    localparam logic [30:0] RST_PPM_LIMIT        = 31'd6553600;
    localparam logic [30:0] RST_CHANGE_THRESHOLD = 31'd6554;
    localparam logic [31:0] RST_SEARCH_TIMEOUT   = 32'd500000;
    localparam logic [3:0]  RST_PUBLISH_PERIOD   = 4'd5;

    // Unity weight in Q1.16; larger alpha values are clamped to it.
    localparam logic [16:0] ALPHA_ONE = 17'd65536;

    localparam logic signed [31:0] OUT_MAX = 32'sd8388607;
    localparam logic signed [31:0] OUT_MIN = -32'sd8388608;

    localparam logic OP_TIME    = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    typedef enum logic [1:0] {
        SYNC_SEARCH,
        SYNC_LOCKED,
        SYNC_LOSS,
        SYNC_OTHER
    } sync_t;

    typedef enum logic [1:0] {
        CAUSE_SEARCH,
        CAUSE_TRACK,
        CAUSE_LOSS,
        CAUSE_TIMEOUT
    } cause_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EVAL,
        BK_AVG,
        BK_STEP,
        BK_CHECK,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic [33:0] ppm_scale;
        logic [16:0] alpha;
        logic [30:0] ppm_limit;
        logic [30:0] change_threshold;
        logic [31:0] search_timeout;
        logic [3:0]  publish_period;
    } cfg_t;

    // Classified word handed from the front end to the back end.
    typedef struct packed {
        logic        op;
        logic [31:0] time_now;
        logic        neg;
        logic [33:0] mag;
        sync_t       sync_state;
    } item_t;

endpackage

FILE: rtl/cot_front.sv
module cot_front
    import cot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [31:0]        time_now,
    input  logic signed [31:0] freq_offset,
    input  logic [1:0]         sync_state,
    output logic               push,
    output item_t              push_item,
    input  logic               full
);

    front_state_t state_reg;
    front_state_t state_next;

    logic        op_reg;
    logic [31:0] time_reg;
    sync_t       sync_reg;
    logic        neg_reg;
    logic [31:0] absf_reg;
    logic [63:0] prod_lo_reg;
    logic [33:0] prod_hi_reg;

    logic [64:0] lo_round;
    logic        accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        case (state_reg)
            FR_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = FR_MUL;
                end
            end
            FR_MUL:
            begin
                state_next = FR_PUSH;
            end
            FR_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    // The magnitude of -2^31 is 2^31, which still fits 32 unsigned bits.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            time_reg <= time_now;
            sync_reg <= sync_t'(sync_state);
            neg_reg  <= freq_offset[31];
            absf_reg <= freq_offset[31] ? (~freq_offset + 32'd1) : freq_offset;
        end
        if (state_reg == FR_MUL)
        begin
            prod_lo_reg <= absf_reg * cfg.ppm_scale[31:0];
            prod_hi_reg <= absf_reg * cfg.ppm_scale[33:32];
        end
    end

    // Round the low partial product to nearest before dropping 32 fraction bits.
    assign lo_round = {1'b0, prod_lo_reg} + 65'h0_8000_0000;

    always_comb
    begin
        push_item.op         = op_reg;
        push_item.time_now   = time_reg;
        push_item.neg        = neg_reg;
        push_item.mag        = prod_hi_reg + {1'b0, lo_round[64:32]};
        push_item.sync_state = sync_reg;
    end

endmodule

FILE: rtl/cot_queue.sv
module cot_queue
    import cot_pkg::*;
#(
    parameter int DEPTH = COT_QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head_item,
    output logic  not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/cot_back.sv
module cot_back
    import cot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] ppm_out,
    output logic [1:0]         cause
);

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        logic signed [23:0] r;
        if (v > OUT_MAX)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < OUT_MIN)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

    back_state_t state_reg, state_next;

    item_t              work_reg, work_next;
    logic signed [31:0] ppm_reg, ppm_next;
    logic signed [50:0] prod_reg, prod_next;
    logic signed [31:0] emit_ppm_reg, emit_ppm_next;
    cause_t             emit_cause_reg, emit_cause_next;

    logic signed [31:0] estimate_reg, estimate_next;
    logic               est_empty_reg, est_empty_next;
    logic signed [31:0] last_pub_reg, last_pub_next;
    logic               pub_valid_reg, pub_valid_next;
    logic [3:0]         counter_reg, counter_next;
    sync_t              last_sync_reg, last_sync_next;
    logic [31:0]        cur_time_reg, cur_time_next;
    logic [31:0]        lmt_reg, lmt_next;
    logic               no_time_reg, no_time_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [23:0] out_ppm_reg, out_ppm_next;
    cause_t             out_cause_reg, out_cause_next;

    logic signed [31:0] ppm_val;
    logic [31:0]        elapsed;
    logic [16:0]        alpha_eff;
    logic signed [32:0] diff;
    logic signed [32:0] dist_raw;
    logic [32:0]        dist_abs;

    // A magnitude within the limit fits 31 bits; a positive offset gives a negative correction.
    assign ppm_val   = work_reg.neg ? $signed({1'b0, work_reg.mag[30:0]})
                                    : -$signed({1'b0, work_reg.mag[30:0]});
    assign elapsed   = work_reg.time_now - lmt_reg;
    assign alpha_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
    assign diff      = {ppm_reg[31], ppm_reg} - {estimate_reg[31], estimate_reg};
    assign dist_raw  = {last_pub_reg[31], last_pub_reg} - {estimate_reg[31], estimate_reg};
    assign dist_abs  = dist_raw[32] ? 33'(-dist_raw) : 33'(dist_raw);

    assign out_valid = out_valid_reg;
    assign ppm_out   = out_ppm_reg;
    assign cause     = out_cause_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            estimate_reg  <= '0;
            est_empty_reg <= 1'b1;
            last_pub_reg  <= '0;
            pub_valid_reg <= 1'b0;
            counter_reg   <= '0;
            last_sync_reg <= SYNC_OTHER;
            cur_time_reg  <= '0;
            lmt_reg       <= '0;
            no_time_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            estimate_reg  <= estimate_next;
            est_empty_reg <= est_empty_next;
            last_pub_reg  <= last_pub_next;
            pub_valid_reg <= pub_valid_next;
            counter_reg   <= counter_next;
            last_sync_reg <= last_sync_next;
            cur_time_reg  <= cur_time_next;
            lmt_reg       <= lmt_next;
            no_time_reg   <= no_time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg       <= work_next;
        ppm_reg        <= ppm_next;
        prod_reg       <= prod_next;
        emit_ppm_reg   <= emit_ppm_next;
        emit_cause_reg <= emit_cause_next;
        out_ppm_reg    <= out_ppm_next;
        out_cause_reg  <= out_cause_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        work_next       = work_reg;
        ppm_next        = ppm_reg;
        prod_next       = prod_reg;
        emit_ppm_next   = emit_ppm_reg;
        emit_cause_next = emit_cause_reg;
        estimate_next   = estimate_reg;
        est_empty_next  = est_empty_reg;
        last_pub_next   = last_pub_reg;
        pub_valid_next  = pub_valid_reg;
        counter_next    = counter_reg;
        last_sync_next  = last_sync_reg;
        cur_time_next   = cur_time_reg;
        lmt_next        = lmt_reg;
        no_time_next    = no_time_reg;
        out_valid_next  = out_valid_reg;
        out_ppm_next    = out_ppm_reg;
        out_cause_next  = out_cause_reg;
        pop             = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    work_next  = q_item;
                    state_next = BK_EVAL;
                end
            end

            BK_EVAL:
            begin
                state_next = BK_IDLE;
                if (work_reg.op == OP_TIME)
                begin
                    cur_time_next = work_reg.time_now;
                    if (no_time_reg)
                    begin
                        lmt_next     = work_reg.time_now;
                        no_time_next = 1'b0;
                    end
                    else if (elapsed > cfg.search_timeout && last_sync_reg == SYNC_SEARCH)
                    begin
                        estimate_next   = '0;
                        est_empty_next  = 1'b1;
                        counter_next    = '0;
                        emit_ppm_next   = '0;
                        emit_cause_next = CAUSE_TIMEOUT;
                        state_next      = BK_EMIT;
                    end
                end
                else
                begin
                    last_sync_next = work_reg.sync_state;
                    if (work_reg.mag > {3'b000, cfg.ppm_limit})
                    begin
                        ppm_next       = '0;
                        estimate_next  = '0;
                        est_empty_next = 1'b1;
                        counter_next   = '0;
                    end
                    else
                    begin
                        ppm_next = ppm_val;
                    end
                    case (work_reg.sync_state)
                        SYNC_SEARCH:
                        begin
                            lmt_next        = cur_time_reg;
                            emit_ppm_next   = ppm_next;
                            emit_cause_next = CAUSE_SEARCH;
                            state_next      = BK_EMIT;
                        end
                        SYNC_LOCKED:
                        begin
                            lmt_next   = cur_time_reg;
                            state_next = BK_AVG;
                        end
                        SYNC_LOSS:
                        begin
                            estimate_next   = '0;
                            est_empty_next  = 1'b1;
                            counter_next    = '0;
                            emit_ppm_next   = '0;
                            emit_cause_next = CAUSE_LOSS;
                            state_next      = BK_EMIT;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end

            BK_AVG:
            begin
                if (est_empty_reg)
                begin
                    estimate_next  = ppm_reg;
                    est_empty_next = 1'b0;
                    state_next     = BK_CHECK;
                end
                else
                begin
                    prod_next  = diff * $signed({1'b0, alpha_eff});
                    state_next = BK_STEP;
                end
            end

            BK_STEP:
            begin
                // Arithmetic shift floors; the new estimate lies between the old one and ppm,
                // so the 32-bit wrapping add is exact.
                estimate_next = estimate_reg + prod_reg[47:16];
                state_next    = BK_CHECK;
            end

            BK_CHECK:
            begin
                state_next = BK_IDLE;
                if (counter_reg == cfg.publish_period)
                begin
                    counter_next = '0;
                    if (!pub_valid_reg || dist_abs > {2'b00, cfg.change_threshold})
                    begin
                        last_pub_next   = estimate_reg;
                        pub_valid_next  = 1'b1;
                        emit_ppm_next   = ppm_reg;
                        emit_cause_next = CAUSE_TRACK;
                        state_next      = BK_EMIT;
                    end
                end
                else
                begin
                    counter_next = counter_reg + 4'd1;
                end
            end

            BK_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_ppm_next   = sat24(emit_ppm_reg);
                    out_cause_next = emit_cause_reg;
                    state_next     = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/clock_offset_tracker_top.sv
// The front end takes one word at a time (accept, 32x32 scale multiply, push) and takes no
// new word until it has pushed the last; the push waits while the queue is full.
// The back end pops and evaluates each word; time updates and search or loss measurements
// may go on to output, tracking ones to averaging multiply, add, publish check and output.
// Reset (rst_n low, asynchronous) restores all configuration defaults and tracking state
// and empties the queue and output register; there is no clearing pass.
module clock_offset_tracker_top
    import cot_pkg::*;
#(
    parameter int QUEUE_DEPTH = COT_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [31:0]           time_now,
    input  logic signed [31:0]    freq_offset,
    input  logic [1:0]            sync_state,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [23:0]    ppm_out,
    output logic [1:0]            cause,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  push;
    item_t push_item;
    logic  full;
    logic  pop;
    item_t head_item;
    logic  not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ppm_scale        <= RST_PPM_SCALE;
            cfg_reg.alpha            <= RST_ALPHA;
            cfg_reg.ppm_limit        <= RST_PPM_LIMIT;
            cfg_reg.change_threshold <= RST_CHANGE_THRESHOLD;
            cfg_reg.search_timeout   <= RST_SEARCH_TIMEOUT;
            cfg_reg.publish_period   <= RST_PUBLISH_PERIOD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PPM_SCALE:        cfg_reg.ppm_scale        <= cfg_data;
                CFG_ALPHA:            cfg_reg.alpha            <= cfg_data[16:0];
                CFG_PPM_LIMIT:        cfg_reg.ppm_limit        <= cfg_data[30:0];
                CFG_CHANGE_THRESHOLD: cfg_reg.change_threshold <= cfg_data[30:0];
                CFG_SEARCH_TIMEOUT:   cfg_reg.search_timeout   <= cfg_data[31:0];
                CFG_PUBLISH_PERIOD:   cfg_reg.publish_period   <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    cot_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .time_now    (time_now),
        .freq_offset (freq_offset),
        .sync_state  (sync_state),
        .push        (push),
        .push_item   (push_item),
        .full        (full)
    );

    cot_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (not_empty)
    );

    cot_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (not_empty),
        .q_item    (head_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ppm_out   (ppm_out),
        .cause     (cause)
    );

endmodule
